// ===== design/bfbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the best-fit bin packer.
package bfbp_pkg;

	localparam int CAP_W    = 17;
	localparam int SPACE_W  = 17;
	localparam int AGE_W    = 32;
	localparam int BIN_W    = 7;
	localparam int STATUS_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

	localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_BIN  = 2'd2;

	typedef struct packed {
		logic               found;
		logic [SPACE_W-1:0] space;
		logic [AGE_W-1:0]   age;
	} bfbp_cand_t;

endpackage

// ===== design/bfbp_in_if.sv =====
`timescale 1ns / 1ps
// Input channel interface carrying one item word.
interface bfbp_in_if #(
	parameter int SIZE_BITS = 17
);
	logic                 valid;
	logic                 ready;
	logic [SIZE_BITS-1:0] item_size;
	logic                 batch_start;

	modport source (output valid, output item_size, output batch_start, input ready);
	modport sink (input valid, input item_size, input batch_start, output ready);
endinterface

// ===== design/bfbp_out_if.sv =====
`timescale 1ns / 1ps
// Output channel interface carrying one placement result word.
interface bfbp_out_if #(
	parameter int SIZE_BITS = 17
);
	logic                               valid;
	logic                               ready;
	logic [bfbp_pkg::BIN_W-1:0]         bin_number;
	logic [SIZE_BITS-1:0]               space_left;
	logic                               opened_bin;
	logic [bfbp_pkg::STATUS_W-1:0]      status;

	modport source (output valid, output bin_number, output space_left, output opened_bin,
		output status, input ready);
	modport sink (input valid, input bin_number, input space_left, input opened_bin,
		input status, output ready);
endinterface

// ===== design/bfbp_cell.sv =====
`timescale 1ns / 1ps
// One bin cell: holds a bin's free space and stamp and passes the best candidate on.
module bfbp_cell #(
	parameter int SIZE_BITS = 17,
	parameter int IDX_W     = 6,
	parameter int OPEN_W    = 7,
	parameter int CELL_IDX  = 0
) (
	input  logic                         clk,
	input  logic [SIZE_BITS-1:0]         item_size,
	input  logic [OPEN_W-1:0]            open_cnt,
	input  logic [bfbp_pkg::AGE_W-1:0]   count,
	input  logic                         wr_en,
	input  logic [bfbp_pkg::SPACE_W-1:0] wr_space,
	input  bfbp_pkg::bfbp_cand_t         cand_in,
	input  logic [IDX_W-1:0]             idx_in,
	output bfbp_pkg::bfbp_cand_t         cand_out,
	output logic [IDX_W-1:0]             idx_out
);

	localparam int CMP_W = (SIZE_BITS > bfbp_pkg::SPACE_W) ? SIZE_BITS : bfbp_pkg::SPACE_W;

	logic [bfbp_pkg::SPACE_W-1:0] free_q;
	logic [bfbp_pkg::AGE_W-1:0]   stamp_q;
	bfbp_pkg::bfbp_cand_t         cand_q;
	logic [IDX_W-1:0]             idx_q;

	logic                         is_open;
	logic                         fits;
	logic [bfbp_pkg::AGE_W-1:0]   age;
	logic                         better;

	// A bin reached its space more recently when its age is smaller.
	assign is_open = OPEN_W'(CELL_IDX) < open_cnt;
	assign fits    = is_open && (CMP_W'(free_q) >= CMP_W'(item_size));
	assign age     = count - stamp_q;
	assign better  = fits && (!cand_in.found || (free_q < cand_in.space) ||
		((free_q == cand_in.space) && (age < cand_in.age)));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			free_q  <= wr_space;
			stamp_q <= count;
		end
		if (better) begin
			cand_q.found <= 1'b1;
			cand_q.space <= free_q;
			cand_q.age   <= age;
			idx_q        <= IDX_W'(CELL_IDX);
		end else begin
			cand_q <= cand_in;
			idx_q  <= idx_in;
		end
	end

	assign cand_out = cand_q;
	assign idx_out  = idx_q;

endmodule

// ===== design/best_fit_bin_packer_top.sv =====
`timescale 1ns / 1ps
// Top level of the online best-fit bin packer built from a chain of bin cells.
//
//   Channel    Dir   Handshake      Word
//   item_in    in    valid/ready    item_size, batch_start
//   result_out out   valid/ready    bin_number, space_left, opened_bin, status
//   cfg        in    cfg_wr_en      cfg_wr_data (bin capacity)
//
// A placed item occupies the block while the best candidate travels through the chain
// of MAX_BINS cells, one cell per cycle; it is committed once the output register is free.
// An item larger than the capacity is committed without waiting for the chain.
// Reset needs no clearing pass; cells are read only once their bin is open.
// A new item is accepted while the previous result still waits in the output register;
// a stalled output only holds the commit of the following item.
module best_fit_bin_packer_top #(
	parameter int MAX_BINS  = 64,
	parameter int SIZE_BITS = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bfbp_in_if.sink                    item_in,
	bfbp_out_if.source                 result_out,
	input  logic                       cfg_wr_en,
	input  logic [bfbp_pkg::CAP_W-1:0] cfg_wr_data
);

	localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int OPEN_W = $clog2(MAX_BINS + 1);
	localparam int STEP_W = $clog2(MAX_BINS + 1);
	localparam int CMP_W  = (SIZE_BITS > bfbp_pkg::SPACE_W) ? SIZE_BITS : bfbp_pkg::SPACE_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                          state_q;
	logic [STEP_W-1:0]             step_q;
	logic [OPEN_W-1:0]             open_q;
	logic [bfbp_pkg::AGE_W-1:0]    cnt_q;
	logic                          too_big_q;
	logic [bfbp_pkg::CAP_W-1:0]    cap_q;
	logic [SIZE_BITS-1:0]          size_q;
	logic                          out_valid_q;
	logic [bfbp_pkg::BIN_W-1:0]    bin_q;
	logic [SIZE_BITS-1:0]          space_q;
	logic                          opened_q;
	logic [bfbp_pkg::STATUS_W-1:0] status_q;

	bfbp_pkg::bfbp_cand_t          chain_cand [MAX_BINS+1];
	logic [IDX_W-1:0]              chain_idx [MAX_BINS+1];
	logic [MAX_BINS-1:0]           wr_sel;

	logic                          accept;
	logic                          done;
	logic                          out_free;
	logic                          commit;
	logic                          full;
	bfbp_pkg::bfbp_cand_t          last;
	logic [CMP_W-1:0]              left_fit;
	logic [CMP_W-1:0]              left_new;

	logic [OPEN_W-1:0]             res_bin;
	logic [CMP_W-1:0]              res_space;
	logic                          res_opened;
	logic [bfbp_pkg::STATUS_W-1:0] res_status;
	logic                          wr_do;
	logic [IDX_W-1:0]              wr_idx;
	logic [bfbp_pkg::SPACE_W-1:0]  wr_space;
	logic                          open_inc;

	assign accept   = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == ST_IDLE);
	assign done     = (state_q == ST_BUSY) && (too_big_q || (step_q == STEP_W'(MAX_BINS)));
	assign out_free = !out_valid_q || result_out.ready;
	assign commit   = done && out_free;
	assign full     = (open_q == OPEN_W'(MAX_BINS));
	assign last     = chain_cand[MAX_BINS];
	assign left_fit = CMP_W'(last.space) - CMP_W'(size_q);
	assign left_new = CMP_W'(cap_q) - CMP_W'(size_q);

	assign chain_cand[0] = '0;
	assign chain_idx[0]  = '0;

	for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
		bfbp_cell #(
			.SIZE_BITS (SIZE_BITS),
			.IDX_W     (IDX_W),
			.OPEN_W    (OPEN_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk       (clk),
			.item_size (size_q),
			.open_cnt  (open_q),
			.count     (cnt_q),
			.wr_en     (wr_sel[g]),
			.wr_space  (wr_space),
			.cand_in   (chain_cand[g]),
			.idx_in    (chain_idx[g]),
			.cand_out  (chain_cand[g+1]),
			.idx_out   (chain_idx[g+1])
		);
	end

	always_comb begin
		res_bin    = '0;
		res_space  = '0;
		res_opened = 1'b0;
		res_status = bfbp_pkg::ST_PLACED;
		wr_do      = 1'b0;
		wr_idx     = '0;
		wr_space   = '0;
		open_inc   = 1'b0;
		if (too_big_q) begin
			res_status = bfbp_pkg::ST_TOO_BIG;
		end else if (last.found) begin
			wr_do     = 1'b1;
			wr_idx    = chain_idx[MAX_BINS];
			wr_space  = left_fit[bfbp_pkg::SPACE_W-1:0];
			res_bin   = OPEN_W'(chain_idx[MAX_BINS]) + 1'b1;
			res_space = left_fit;
		end else if (full) begin
			res_status = bfbp_pkg::ST_NO_BIN;
		end else begin
			wr_do      = 1'b1;
			wr_idx     = open_q[IDX_W-1:0];
			wr_space   = left_new[bfbp_pkg::SPACE_W-1:0];
			res_bin    = open_q + 1'b1;
			res_space  = left_new;
			res_opened = 1'b1;
			open_inc   = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_BINS; i++) begin
			wr_sel[i] = commit && wr_do && (wr_idx == IDX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			open_q      <= '0;
			cnt_q       <= '0;
			too_big_q   <= 1'b0;
			cap_q       <= bfbp_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (accept) begin
				state_q   <= ST_BUSY;
				step_q    <= '0;
				cnt_q     <= cnt_q + 1'b1;
				too_big_q <= CMP_W'(item_in.item_size) > CMP_W'(cap_q);
				if (item_in.batch_start) begin
					open_q <= '0;
				end
			end else if (state_q == ST_BUSY) begin
				if (!done) begin
					step_q <= step_q + 1'b1;
				end
				if (commit) begin
					state_q <= ST_IDLE;
					if (open_inc) begin
						open_q <= open_q + 1'b1;
					end
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q <= item_in.item_size;
		end
		if (commit) begin
			bin_q    <= bfbp_pkg::BIN_W'(res_bin);
			space_q  <= SIZE_BITS'(res_space);
			opened_q <= res_opened;
			status_q <= res_status;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.bin_number = bin_q;
	assign result_out.space_left = space_q;
	assign result_out.opened_bin = opened_q;
	assign result_out.status     = status_q;

endmodule

// ===== design/bfbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bin packer and the bind that attaches them.
module bfbp_checker #(
	parameter int SIZE_BITS = 17
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bfbp_pkg::BIN_W-1:0]    bin_number,
	input logic [SIZE_BITS-1:0]          space_left,
	input logic                          opened_bin,
	input logic [bfbp_pkg::STATUS_W-1:0] status
);

	// An item that was not placed carries no bin, space or open flag.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != bfbp_pkg::ST_PLACED)) |->
		((bin_number == '0) && (space_left == '0) && !opened_bin))
		else $error("rejected word carries placement fields");

	// Opening a bin is only reported for a placed item.
	a_open_placed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && opened_bin) |-> (status == bfbp_pkg::ST_PLACED))
		else $error("opened bin reported with error status");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an accepted word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");

endmodule

bind best_fit_bin_packer_top bfbp_checker #(
	.SIZE_BITS (SIZE_BITS)
) u_bfbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item_in.valid),
	.in_ready   (item_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.bin_number (result_out.bin_number),
	.space_left (result_out.space_left),
	.opened_bin (result_out.opened_bin),
	.status     (result_out.status)
);
